FILE: src/ffba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ffba_pkg;

   localparam int FREE_ENTRIES = 16;
   localparam int HEAP_BYTES   = 1048576;
   localparam int ALIGN_BYTES  = 16;

   localparam int OFF_W  = 20;
   localparam int SIZE_W = 21;
   localparam int NEED_W = SIZE_W + 1;
   localparam int END_W  = SIZE_W + 2;
   localparam int IDX_W  = $clog2(FREE_ENTRIES);
   localparam int CNT_W  = $clog2(FREE_ENTRIES + 1);
   localparam int ADDR_W = 3;
   localparam int DATA_W = 32;

   localparam logic [SIZE_W-1:0] LIMIT_MAX  = SIZE_W'(HEAP_BYTES);
   localparam logic [NEED_W-1:0] ALIGN_MASK = NEED_W'(ALIGN_BYTES - 1);
   localparam logic [SIZE_W-1:0] LIMIT_RST  = SIZE_W'(1048576);

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_NOSPACE = 2'd1;
   localparam logic [1:0] STATUS_DROPPED = 2'd2;

   localparam logic REG_HEAP_LIMIT = 1'b0;

   typedef struct packed {
      logic              cmd;
      logic [SIZE_W-1:0] request_length;
      logic [OFF_W-1:0]  release_offset;
      logic [SIZE_W-1:0] release_length;
   } req_type;

   typedef struct packed {
      logic [OFF_W-1:0]  block_offset;
      logic [SIZE_W-1:0] block_capacity;
      logic              reused;
      logic [1:0]        status;
   } rsp_type;

   typedef struct packed {
      logic [OFF_W-1:0]  start;
      logic [SIZE_W-1:0] size;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MOVE,
      ST_CARVE,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

FILE: src/first_fit_block_allocator.sv
// First-fit heap block allocator with a 16-entry free list.
// Request channel (req_valid/req_stall/req_data): one beat is an allocate or a
// free command. Response channel (rsp_valid/rsp_stall/rsp_data): exactly one
// beat per request, in request order.
// Config port (APB style, pready tied high): heap_limit at byte address 0.
// Write it only while the block is idle.
// Flow: a request is registered when taken, then the free list is scanned one
// entry per cycle through the single read port of the list RAM, whose read
// data is registered. An allocate hit then moves the last entry into the
// vacated slot; a miss instead carves at the heap top. A zero-length free
// skips the scan and goes straight to the response. req_stall is high while
// a request is in progress.
// The response sits in an output register; a new request is accepted while it
// waits. If rsp_stall holds the previous beat, the finished result waits in
// the final state until the register frees up.
// Reset (synchronous): empty free list, heap top 0, heap_limit 1048576. The
// list RAM itself is not cleared; only entries below the count are read.
`timescale 1ns / 1ps
`default_nettype none

module first_fit_block_allocator
   import ffba_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire req_type           req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output rsp_type                rsp_data,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [ADDR_W-1:0] paddr,
   input  wire logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0]      prdata,
   output logic                   pready
);

   entry_type mem [FREE_ENTRIES];

   state_type         state_ff, state_in;
   req_type           req_ff, req_in;
   logic [NEED_W-1:0] need_ff, need_in;
   logic [CNT_W-1:0]  scan_idx_ff, scan_idx_in;
   logic              chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0]  chk_idx_ff, chk_idx_in;
   logic [IDX_W-1:0]  hit_idx_ff, hit_idx_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [SIZE_W-1:0] heap_top_ff, heap_top_in;
   logic [SIZE_W-1:0] heap_limit_ff, heap_limit_in;
   rsp_type           res_ff, res_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;
   entry_type         rd_ff;

   logic [IDX_W-1:0]  rd_addr;
   logic              mem_we;
   logic [IDX_W-1:0]  mem_waddr;
   entry_type         mem_wdata;

   logic              cfg_wr;
   logic              hit;
   logic              adj_below;
   logic              adj_above;
   logic [NEED_W-1:0] blk_end;
   logic [NEED_W-1:0] rel_end;
   logic [NEED_W-1:0] sum_raw;
   logic [SIZE_W-1:0] sum_sat;
   logic [END_W-1:0]  carve_end;
   logic [SIZE_W-1:0] limit;
   logic [CNT_W-1:0]  last_cnt;
   logic [NEED_W-1:0] need_raw;

   assign pready    = 1'b1;
   assign cfg_wr    = psel && penable && pwrite;
   assign prdata    = (paddr[2] == REG_HEAP_LIMIT)
                      ? DATA_W'(heap_limit_ff) : '0;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign blk_end   = {2'b00, rd_ff.start} + {1'b0, rd_ff.size};
   assign rel_end   = {2'b00, req_ff.release_offset} + {1'b0, req_ff.release_length};
   assign sum_raw   = {1'b0, rd_ff.size} + {1'b0, req_ff.release_length};
   assign sum_sat   = sum_raw[SIZE_W] ? '1 : sum_raw[SIZE_W-1:0];
   assign adj_below = (blk_end == {2'b00, req_ff.release_offset});
   assign adj_above = (rel_end == {2'b00, rd_ff.start});
   assign carve_end = {2'b00, heap_top_ff} + {1'b0, need_ff};
   assign limit     = (heap_limit_ff < LIMIT_MAX) ? heap_limit_ff : LIMIT_MAX;
   assign last_cnt  = count_ff - CNT_W'(1);
   assign need_raw  = ({1'b0, req_data.request_length} + ALIGN_MASK) & ~ALIGN_MASK;

   always_comb begin
      if (req_ff.cmd == CMD_ALLOC) begin
         hit = chk_vld_ff && ({1'b0, rd_ff.size} >= need_ff);
      end else begin
         hit = chk_vld_ff && (adj_below || adj_above);
      end
   end

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      need_in       = need_ff;
      scan_idx_in   = scan_idx_ff;
      chk_vld_in    = 1'b0;
      chk_idx_in    = chk_idx_ff;
      hit_idx_in    = hit_idx_ff;
      count_in      = count_ff;
      heap_top_in   = heap_top_ff;
      heap_limit_in = heap_limit_ff;
      res_in        = res_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      rd_addr       = scan_idx_ff[IDX_W-1:0];
      mem_we        = 1'b0;
      mem_waddr     = chk_idx_ff;
      mem_wdata     = rd_ff;

      if (cfg_wr && (paddr[2] == REG_HEAP_LIMIT)) begin
         heap_limit_in = pwdata[SIZE_W-1:0];
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in      = req_data;
               need_in     = need_raw;
               scan_idx_in = '0;
               res_in      = '0;
               if ((req_data.cmd == CMD_FREE) && (req_data.release_length == '0)) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (hit) begin
               if (req_ff.cmd == CMD_ALLOC) begin
                  res_in.block_offset   = rd_ff.start;
                  res_in.block_capacity = rd_ff.size;
                  res_in.reused         = 1'b1;
                  res_in.status         = STATUS_OK;
                  rd_addr               = last_cnt[IDX_W-1:0];
                  hit_idx_in            = chk_idx_ff;
                  state_in              = ST_MOVE;
               end else begin
                  mem_we         = 1'b1;
                  mem_waddr      = chk_idx_ff;
                  mem_wdata.size = sum_sat;
                  if (adj_below) begin
                     mem_wdata.start = rd_ff.start;
                  end else begin
                     mem_wdata.start = req_ff.release_offset;
                  end
                  state_in = ST_DONE;
               end
            end else if (scan_idx_ff < count_ff) begin
               rd_addr     = scan_idx_ff[IDX_W-1:0];
               chk_vld_in  = 1'b1;
               chk_idx_in  = scan_idx_ff[IDX_W-1:0];
               scan_idx_in = scan_idx_ff + CNT_W'(1);
            end else if (req_ff.cmd == CMD_ALLOC) begin
               state_in = ST_CARVE;
            end else begin
               if (count_ff < CNT_W'(FREE_ENTRIES)) begin
                  mem_we          = 1'b1;
                  mem_waddr       = count_ff[IDX_W-1:0];
                  mem_wdata.start = req_ff.release_offset;
                  mem_wdata.size  = req_ff.release_length;
                  count_in        = count_ff + CNT_W'(1);
               end else begin
                  res_in.status = STATUS_DROPPED;
               end
               state_in = ST_DONE;
            end
         end
         ST_MOVE: begin
            mem_we    = 1'b1;
            mem_waddr = hit_idx_ff;
            mem_wdata = rd_ff;
            count_in  = last_cnt;
            state_in  = ST_DONE;
         end
         ST_CARVE: begin
            if (carve_end > {2'b00, limit}) begin
               res_in.status = STATUS_NOSPACE;
            end else begin
               res_in.block_offset   = heap_top_ff[OFF_W-1:0];
               res_in.block_capacity = need_ff[SIZE_W-1:0];
               res_in.reused         = 1'b0;
               res_in.status         = STATUS_OK;
               heap_top_in           = carve_end[SIZE_W-1:0];
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         chk_vld_ff    <= 1'b0;
         count_ff      <= '0;
         heap_top_ff   <= '0;
         heap_limit_ff <= LIMIT_RST;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         chk_vld_ff    <= chk_vld_in;
         count_ff      <= count_in;
         heap_top_ff   <= heap_top_in;
         heap_limit_ff <= heap_limit_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      need_ff     <= need_in;
      scan_idx_ff <= scan_idx_in;
      chk_idx_ff  <= chk_idx_in;
      hit_idx_ff  <= hit_idx_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_ff <= mem[rd_addr];
   end

endmodule

`default_nettype wire

FILE: tb/ffba_grant_checker.sv
`timescale 1ns / 1ps

module ffba_grant_checker
   import ffba_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_stall,
   input  wire req_type           req_data,
   input  wire logic              rsp_valid,
   input  wire logic              rsp_stall,
   input  wire rsp_type           rsp_data,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic              pready,
   input  wire logic [ADDR_W-1:0] paddr,
   input  wire logic [DATA_W-1:0] pwdata,
   output int                     failures,
   output int                     grants_due
);

   localparam logic [ADDR_W-1:0] HEAP_LIMIT_ADDR = ADDR_W'(4 * REG_HEAP_LIMIT);
   localparam logic [NEED_W-1:0] SIZE_SAT        = NEED_W'({SIZE_W{1'b1}});

   logic [OFF_W-1:0]  hole_start [FREE_ENTRIES];
   logic [SIZE_W-1:0] hole_size  [FREE_ENTRIES];
   int                hole_count;
   logic [SIZE_W-1:0] heap_mark;
   logic [SIZE_W-1:0] limit_copy;
   rsp_type           grant_q [$];

   function automatic rsp_type allot_or_release(req_type r);
      rsp_type           res;
      logic [NEED_W-1:0] need;
      logic [NEED_W-1:0] sum;
      logic [NEED_W-1:0] hole_end;
      logic [NEED_W-1:0] rel_end;
      logic [END_W-1:0]  carve_end;
      logic [END_W-1:0]  ceiling;
      int                last;
      bit                done;
      res  = '0;
      done = 1'b0;
      if (r.cmd == CMD_ALLOC) begin
         need = (NEED_W'(r.request_length) + NEED_W'(ALIGN_BYTES - 1)) / NEED_W'(ALIGN_BYTES)
                * NEED_W'(ALIGN_BYTES);
         for (int i = 0; i < hole_count; i++) begin
            if (NEED_W'(hole_size[i]) >= need) begin
               last               = hole_count - 1;
               res.block_offset   = hole_start[i];
               res.block_capacity = hole_size[i];
               res.reused         = 1'b1;
               hole_start[i]      = hole_start[last];
               hole_size[i]       = hole_size[last];
               hole_count         = last;
               done               = 1'b1;
               break;
            end
         end
         if (!done) begin
            carve_end = END_W'(heap_mark) + END_W'(need);
            ceiling   = (END_W'(limit_copy) < END_W'(HEAP_BYTES)) ? END_W'(limit_copy)
                                                                   : END_W'(HEAP_BYTES);
            if (carve_end > ceiling) begin
               res.status = STATUS_NOSPACE;
            end else begin
               res.block_offset   = heap_mark[OFF_W-1:0];
               res.block_capacity = need[SIZE_W-1:0];
               heap_mark          = carve_end[SIZE_W-1:0];
            end
         end
      end else if (r.release_length != '0) begin
         for (int i = 0; i < hole_count; i++) begin
            sum      = NEED_W'(hole_size[i]) + NEED_W'(r.release_length);
            if (sum > SIZE_SAT) sum = SIZE_SAT;
            hole_end = NEED_W'(hole_start[i]) + NEED_W'(hole_size[i]);
            rel_end  = NEED_W'(r.release_offset) + NEED_W'(r.release_length);
            if (hole_end == NEED_W'(r.release_offset)) begin
               hole_size[i] = sum[SIZE_W-1:0];
               done         = 1'b1;
               break;
            end
            if (rel_end == NEED_W'(hole_start[i])) begin
               hole_start[i] = r.release_offset;
               hole_size[i]  = sum[SIZE_W-1:0];
               done          = 1'b1;
               break;
            end
         end
         if (!done) begin
            if (hole_count < FREE_ENTRIES) begin
               hole_start[hole_count] = r.release_offset;
               hole_size[hole_count]  = r.release_length;
               hole_count++;
            end else begin
               res.status = STATUS_DROPPED;
            end
         end
      end
      return res;
   endfunction

   task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         failures++;
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      end
   endtask

   initial failures = 0;

   always @(posedge clock) begin
      rsp_type want;
      rsp_type fresh;
      if (reset) begin
         hole_count = 0;
         heap_mark  = '0;
         limit_copy = LIMIT_RST;
         grant_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (grant_q.size() == 0) begin
               failures++;
               $display("%0t: response beat with none expected, expected none actual %0h",
                        $time, rsp_data);
            end else begin
               want = grant_q.pop_front();
               compare_field("block_offset", 32'(want.block_offset), 32'(rsp_data.block_offset));
               compare_field("block_capacity", 32'(want.block_capacity),
                             32'(rsp_data.block_capacity));
               compare_field("reused", 32'(want.reused), 32'(rsp_data.reused));
               compare_field("status", 32'(want.status), 32'(rsp_data.status));
            end
         end
         if (req_valid && !req_stall) begin
            fresh   = allot_or_release(req_data);
            grant_q = {grant_q, fresh};
         end
         if (psel && penable && pwrite && pready && paddr == HEAP_LIMIT_ADDR)
            limit_copy = pwdata[SIZE_W-1:0];
      end
      grants_due = grant_q.size();
   end

endmodule

FILE: tb/tb_first_fit_block_allocator.sv
`timescale 1ns / 1ps

module tb_first_fit_block_allocator;
   import ffba_pkg::*;

   localparam logic [ADDR_W-1:0] HEAP_LIMIT_ADDR = ADDR_W'(4 * REG_HEAP_LIMIT);
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int HOLD_CYCLES    = 400;
   localparam int HOLD_AT_A      = 1500;
   localparam int HOLD_AT_B      = 7000;

   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_type;

   typedef struct {
      logic [OFF_W-1:0]  off;
      logic [SIZE_W-1:0] cap;
   } block_span_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   req_type           req_data;
   logic              rsp_valid;
   logic              rsp_stall;
   rsp_type           rsp_data;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [ADDR_W-1:0] paddr;
   logic [DATA_W-1:0] pwdata;
   logic [DATA_W-1:0] prdata;
   logic              pready;
   int                failures;
   int                grants_due;

   block_span_type    live_blocks [$];
   logic [SIZE_W-1:0] top_seen = '0;
   int                burst_left = 0;
   int                quiet_cycles;

   first_fit_block_allocator dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   ffba_grant_checker grant_chk (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .pready     (pready),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .failures   (failures),
      .grants_due (grants_due)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic req_type alloc_req(logic [SIZE_W-1:0] len);
      req_type r;
      r.cmd            = CMD_ALLOC;
      r.request_length = len;
      r.release_offset = OFF_W'($urandom);
      r.release_length = SIZE_W'($urandom);
      return r;
   endfunction

   function automatic req_type free_req(logic [OFF_W-1:0] off, logic [SIZE_W-1:0] len);
      req_type r;
      r.cmd            = CMD_FREE;
      r.request_length = SIZE_W'($urandom);
      r.release_offset = off;
      r.release_length = len;
      return r;
   endfunction

   task automatic pause_sender(int n);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (n - 1) @(negedge clock);
   endtask

   task automatic issue(req_type r);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
         if (gap > 0) pause_sender(gap);
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic wait_idle();
      pause_sender(1);
      while (grants_due != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_heap_limit(logic [DATA_W-1:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= HEAP_LIMIT_ADDR;
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // spaced frees, one more than the list holds
   task automatic fill_free_list();
      logic [OFF_W-1:0] base;
      base = OFF_W'($urandom_range(0, 32'hEF0) << 8);
      for (int k = 0; k <= FREE_ENTRIES; k++)
         issue(free_req(base + OFF_W'(k * 256), SIZE_W'($urandom_range(1, 200))));
   endtask

   task automatic random_traffic(int n);
      int                made;
      int                pick;
      int                idx;
      block_span_type    b;
      logic [SIZE_W-1:0] len;
      made = 0;
      while (made < n) begin
         pick = $urandom_range(0, 99);
         if (pick < 2) begin
            fill_free_list();
            made += FREE_ENTRIES + 1;
         end else if (pick < 12) begin
            case ($urandom_range(0, 2))
               0: len = '0;
               1: len = SIZE_W'($urandom_range(1, 256));
               default: len = SIZE_W'($urandom);
            endcase
            issue(free_req(OFF_W'($urandom), len));
            made++;
         end else if (pick < 55 || live_blocks.size() == 0) begin
            pick = $urandom_range(0, 99);
            if (pick < 80)      len = SIZE_W'($urandom_range(0, 300));
            else if (pick < 96) len = SIZE_W'($urandom_range(0, 4096));
            else                len = SIZE_W'((1 << 20) | ($urandom & 32'hFFFFF));
            issue(alloc_req(len));
            made++;
         end else begin
            idx = $urandom_range(0, live_blocks.size() - 1);
            b   = live_blocks[idx];
            live_blocks.delete(idx);
            len = b.cap;
            if ($urandom_range(0, 4) == 0) len = len - SIZE_W'(16);
            issue(free_req(b.off, len));
            made++;
         end
      end
   endtask

   // granted blocks feed the frees; carves track the heap top
   always @(posedge clock) begin
      block_span_type b;
      if (!reset && rsp_valid && !rsp_stall && rsp_data.status == STATUS_OK) begin
         if (!rsp_data.reused && rsp_data.block_capacity != '0)
            top_seen <= SIZE_W'(rsp_data.block_offset) + rsp_data.block_capacity;
         if (rsp_data.block_capacity >= 16 && rsp_data.block_capacity <= 4096) begin
            b.off       = rsp_data.block_offset;
            b.cap       = rsp_data.block_capacity;
            live_blocks = {live_blocks, b};
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
                   (psel && penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_first_fit_block_allocator: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int             cyc;
      int             hold_left;
      int             mode_left;
      int             period;
      stall_mode_type mode;
      rsp_stall = 1'b0;
      cyc       = 0;
      hold_left = 0;
      mode_left = 0;
      period    = 3;
      mode      = STALL_NONE;
      forever begin
         @(negedge clock);
         cyc++;
         if (cyc == HOLD_AT_A || cyc == HOLD_AT_B) hold_left = HOLD_CYCLES;
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            if (mode_left == 0) begin
               mode      = stall_mode_type'($urandom_range(0, 3));
               mode_left = $urandom_range(10, 150);
               period    = $urandom_range(2, 7);
            end
            mode_left--;
            case (mode)
               STALL_NONE:  rsp_stall <= 1'b0;
               STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
               STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
               default:     rsp_stall <= ((cyc % period) == 0);
            endcase
         end
      end
   end

   initial begin
      req_valid = 1'b0;
      req_data  = '0;
      psel      = 1'b0;
      penable   = 1'b0;
      pwrite    = 1'b0;
      paddr     = '0;
      pwdata    = '0;
      reset     = 1'b1;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      issue(alloc_req('0));
      issue(alloc_req(SIZE_W'(1)));
      issue(alloc_req(SIZE_W'(16)));
      issue(alloc_req(SIZE_W'(17)));
      issue(free_req(OFF_W'(0), '0));
      issue(free_req(OFF_W'(0), SIZE_W'(16)));
      issue(free_req(OFF_W'(16), SIZE_W'(16)));
      issue(free_req(OFF_W'(100), SIZE_W'(20)));
      issue(free_req(OFF_W'(80), SIZE_W'(20)));
      issue(alloc_req('0));
      issue(alloc_req({SIZE_W{1'b1}}));
      issue(alloc_req(SIZE_W'(HEAP_BYTES)));
      issue(free_req(OFF_W'(32'h80000), {SIZE_W{1'b1}}));
      issue(free_req(OFF_W'(0), SIZE_W'(32'h80000)));
      issue(free_req({OFF_W{1'b1}}, {SIZE_W{1'b1}}));
      issue(free_req(OFF_W'(32'hFFFFE), SIZE_W'(2)));
      issue(alloc_req(SIZE_W'(32'h1FFFF0)));
      issue(alloc_req(SIZE_W'(48)));
      issue(alloc_req(SIZE_W'(32)));
      issue(alloc_req('0));

      wait_idle();
      write_heap_limit(32'hFFFF_FFFF);
      fill_free_list();
      random_traffic(80);

      wait_idle();
      write_heap_limit(DATA_W'(top_seen) + DATA_W'($urandom_range(0, 4096)));
      random_traffic(80);

      wait_idle();
      write_heap_limit('0);
      random_traffic(80);

      wait_idle();
      write_heap_limit(DATA_W'($urandom_range(0, HEAP_BYTES)));
      random_traffic(80);

      wait_idle();
      write_heap_limit(DATA_W'(LIMIT_RST));
      random_traffic(80);

      // carve the heap up to its very top, then empty the list
      repeat (3) begin
         wait_idle();
         if (top_seen < SIZE_W'(HEAP_BYTES)) issue(alloc_req(SIZE_W'(HEAP_BYTES) - top_seen));
      end
      wait_idle();
      repeat (FREE_ENTRIES + 2) issue(alloc_req('0));
      issue(alloc_req(SIZE_W'(16)));

      wait_idle();
      repeat (40) @(negedge clock);
      if (failures == 0 && grants_due == 0) begin
         $display("tb_first_fit_block_allocator: PASS");
      end else begin
         $display("tb_first_fit_block_allocator: FAIL");
      end
      $finish;
   end

endmodule
